@@ rtl/diff_drive_speed_frame_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the differential-drive speed frame encoder
// Short forms for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_SPEED_FRAME_ENCODER_MACROS_SVH
`define DIFF_DRIVE_SPEED_FRAME_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDSFE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDSFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ddsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// ddsfe_pkg
// Shared types and constants of the speed frame encoder.
// ----------------------------------------------------------------------------
package ddsfe_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_LINEAR_LIMIT  = 3'd0;
   localparam logic [2:0] REG_ANGULAR_LIMIT = 3'd1;
   localparam logic [2:0] REG_TRACK_WIDTH   = 3'd2;
   localparam logic [2:0] REG_SPEED_SCALE   = 3'd3;
   localparam logic [2:0] REG_DEVICE_ID     = 3'd4;

   // Fixed frame bytes.
   localparam logic [7:0] HEAD_BYTE = 8'h3C;
   localparam logic [7:0] LEN_BYTE  = 8'h0D;
   localparam logic [7:0] CMD1_BYTE = 8'h01;
   localparam logic [7:0] CMD2_BYTE = 8'h54;
   localparam logic [7:0] TAIL_BYTE = 8'h3E;
   localparam logic [7:0] FIXED_SUM = HEAD_BYTE + LEN_BYTE + CMD1_BYTE + CMD2_BYTE;

   // Byte positions inside a frame.
   localparam logic [3:0] POS_HEAD   = 4'd0;
   localparam logic [3:0] POS_ID     = 4'd1;
   localparam logic [3:0] POS_LEN    = 4'd2;
   localparam logic [3:0] POS_CMD1   = 4'd3;
   localparam logic [3:0] POS_CMD2   = 4'd4;
   localparam logic [3:0] POS_RIGHT0 = 4'd5;
   localparam logic [3:0] POS_RIGHT1 = 4'd6;
   localparam logic [3:0] POS_RIGHT2 = 4'd7;
   localparam logic [3:0] POS_RIGHT3 = 4'd8;
   localparam logic [3:0] POS_LEFT0  = 4'd9;
   localparam logic [3:0] POS_LEFT1  = 4'd10;
   localparam logic [3:0] POS_LEFT2  = 4'd11;
   localparam logic [3:0] POS_LEFT3  = 4'd12;
   localparam logic [3:0] POS_CSUM   = 4'd13;
   localparam logic [3:0] POS_TAIL   = 4'd14;

   // Widths of the wheel datapath.
   localparam int MAG_W   = 63;             // magnitude of a wheel sum
   localparam int SCALE_W = 16;
   localparam int PROD_W  = MAG_W + SCALE_W; // exact scaled magnitude
   localparam int NORM_W  = PROD_W + 1;      // padded to whole bytes
   localparam int NORM_BYTES = NORM_W / 8;

   // Register stages from accepted command to finished frame record.
   localparam int FRONT_STAGES = 10;

   typedef struct packed {
      logic [30:0] linear_limit;
      logic [30:0] angular_limit;
      logic [30:0] track_width;
      logic [15:0] speed_scale;
      logic [7:0]  device_id;
   } cfg_type;

   typedef struct packed {
      logic [31:0] right_bits;
      logic [31:0] left_bits;
      logic [7:0]  checksum;
   } frame_rec_type;

endpackage

@@ rtl/ddsfe_cvt.sv @@
// ----------------------------------------------------------------------------
// ddsfe_cvt
// Five-stage scale, normalize and round of one wheel value to IEEE single.
// ----------------------------------------------------------------------------
module ddsfe_cvt #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           neg,
   input  logic [ddsfe_pkg::MAG_W-1:0]    mag,
   input  logic [ddsfe_pkg::SCALE_W-1:0]  scale,
   output logic [31:0]                    bits
);
   import ddsfe_pkg::*;

   // Exponent field for a leading one at the top of the normalized word.
   localparam int EXP_BASE = (NORM_W - 2) + 126 - (2 * FRAC_BITS + 1);
   // Partial products of the low 32 and the high bits of the magnitude.
   localparam int LO_W = 32 + SCALE_W;
   localparam int HI_W = MAG_W - 32 + SCALE_W;

   logic              neg0_ff, neg1_ff, neg2_ff, neg3_ff;
   logic [LO_W-1:0]   lo_prod_ff;
   logic [HI_W-1:0]   hi_prod_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [NORM_W-1:0] coarse_ff, coarse_in;
   logic [3:0]        grp_ff, grp_in;
   logic              zero2_ff, zero3_ff;
   logic [NORM_W-1:0] norm_ff, norm_in;
   logic [6:0]        lz_ff, lz_in;
   logic [2:0]        fine_z;
   logic [31:0]       bits_ff, bits_in;
   logic [NORM_W-1:0] padded;
   logic [23:0]       mant;
   logic [24:0]       mant_rnd;
   logic              guard, sticky;
   logic [7:0]        exp_val;

   // Stage 3: find the leading nonzero byte and shift it to the top.
   always_comb begin
      padded = {prod_ff, 1'b0};
      grp_in = '0;
      for (int i = 0; i < NORM_BYTES; i++) begin
         if (padded[8*i +: 8] != 8'h00) begin
            grp_in = 4'(NORM_BYTES - 1 - i);
         end
      end
      coarse_in = padded << {grp_in, 3'b000};
   end

   // Stage 4: finish the shift within the top byte.
   always_comb begin
      fine_z = '0;
      for (int i = 0; i < 8; i++) begin
         if (coarse_ff[NORM_W-8+i]) begin
            fine_z = 3'(7 - i);
         end
      end
      norm_in = coarse_ff << fine_z;
      lz_in   = {grp_ff, 3'b000} + {4'b0000, fine_z};
   end

   // Stage 5: round to nearest even and pack.
   always_comb begin
      mant     = norm_ff[NORM_W-1 -: 24];
      guard    = norm_ff[NORM_W-25];
      sticky   = |norm_ff[NORM_W-26:0];
      mant_rnd = {1'b0, mant} + {24'd0, guard & (sticky | mant[0])};
      exp_val  = 8'(EXP_BASE) - {1'b0, lz_ff};
      bits_in  = {1'b0, exp_val, 23'd0} + {7'd0, mant_rnd};
      if (zero3_ff) begin
         bits_in = '0;
      end else if (neg3_ff) begin
         bits_in[31] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      // Stages 1 and 2: two narrow partial products, then their sum.
      lo_prod_ff <= {{SCALE_W{1'b0}}, mag[31:0]} * {32'd0, scale};
      hi_prod_ff <= {{SCALE_W{1'b0}}, mag[MAG_W-1:32]} * {{(MAG_W-32){1'b0}}, scale};
      neg0_ff    <= neg;
      prod_ff    <= {{(PROD_W-LO_W){1'b0}}, lo_prod_ff} + {hi_prod_ff, 32'd0};
      neg1_ff    <= neg0_ff;
      coarse_ff  <= coarse_in;
      grp_ff     <= grp_in;
      zero2_ff   <= (prod_ff == '0);
      neg2_ff    <= neg1_ff;
      norm_ff    <= norm_in;
      lz_ff      <= lz_in;
      zero3_ff   <= zero2_ff;
      neg3_ff    <= neg2_ff;
      bits_ff    <= bits_in;
   end

   assign bits = bits_ff;

endmodule

@@ rtl/ddsfe_front.sv @@
// ----------------------------------------------------------------------------
// ddsfe_front
// Clamps a command, splits it into wheel values and builds the frame record.
// ----------------------------------------------------------------------------
module ddsfe_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic signed [31:0]                       linear_velocity,
   input  logic signed [31:0]                       angular_velocity,
   input  ddsfe_pkg::cfg_type                       cfg,
   output logic                                     out_valid,
   output ddsfe_pkg::frame_rec_type                 out_rec,
   output logic [ddsfe_pkg::FRONT_STAGES-1:0]       stage_valid
);
   import ddsfe_pkg::*;

   function automatic logic signed [31:0] clamp_sym(logic signed [31:0] v,
                                                    logic [30:0] lim);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = $signed({1'b0, lim});
      lo = -hi;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   logic [FRONT_STAGES-1:0] vld_ff;
   logic signed [31:0]      lin_ff, ang_ff;
   logic signed [63:0]      base_ff, turn_ff, turn_prod;
   logic signed [63:0]      rsum_ff, lsum_ff;
   logic [MAG_W-1:0]        rmag_ff, lmag_ff;
   logic                    rneg_ff, lneg_ff;
   logic [63:0]             rabs, labs;
   logic [31:0]             rbits, lbits;
   logic [7:0]              sum8;
   frame_rec_type           rec_ff;

   assign turn_prod = ang_ff * $signed({1'b0, cfg.track_width});
   assign rabs = rsum_ff[63] ? 64'(-rsum_ff) : 64'(rsum_ff);
   assign labs = lsum_ff[63] ? 64'(-lsum_ff) : 64'(lsum_ff);

   always_ff @(posedge clock) begin
      lin_ff  <= clamp_sym(linear_velocity, cfg.linear_limit);
      ang_ff  <= clamp_sym(angular_velocity, cfg.angular_limit);
      base_ff <= {{32{lin_ff[31]}}, lin_ff} <<< (FRAC_BITS + 1);
      turn_ff <= turn_prod;
      rsum_ff <= base_ff + turn_ff;
      lsum_ff <= base_ff - turn_ff;
      rneg_ff <= rsum_ff[63];
      lneg_ff <= lsum_ff[63];
      rmag_ff <= rabs[MAG_W-1:0];
      lmag_ff <= labs[MAG_W-1:0];
   end

   ddsfe_cvt #(.FRAC_BITS(FRAC_BITS)) u_cvt_right (
      .clock (clock),
      .neg   (rneg_ff),
      .mag   (rmag_ff),
      .scale (cfg.speed_scale),
      .bits  (rbits)
   );

   ddsfe_cvt #(.FRAC_BITS(FRAC_BITS)) u_cvt_left (
      .clock (clock),
      .neg   (lneg_ff),
      .mag   (lmag_ff),
      .scale (cfg.speed_scale),
      .bits  (lbits)
   );

   // Checksum covers the fixed bytes, the id and both speeds.
   always_comb begin
      sum8 = FIXED_SUM + cfg.device_id
           + rbits[7:0] + rbits[15:8] + rbits[23:16] + rbits[31:24]
           + lbits[7:0] + lbits[15:8] + lbits[23:16] + lbits[31:24];
   end

   always_ff @(posedge clock) begin
      rec_ff.right_bits <= rbits;
      rec_ff.left_bits  <= lbits;
      rec_ff.checksum   <= 8'h00 - sum8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   assign out_valid   = vld_ff[FRONT_STAGES-1];
   assign out_rec     = rec_ff;
   assign stage_valid = vld_ff;

endmodule

@@ rtl/ddsfe_queue.sv @@
// ----------------------------------------------------------------------------
// ddsfe_queue
// Short queue of finished frame records between the front and the back.
// ----------------------------------------------------------------------------
module ddsfe_queue #(
   parameter int DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  ddsfe_pkg::frame_rec_type          wr_rec,
   input  logic                              rd_en,
   output ddsfe_pkg::frame_rec_type          rd_rec,
   output logic                              empty,
   output logic [$clog2(DEPTH+1)-1:0]        count
);
   import ddsfe_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   frame_rec_type   mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   function automatic logic [PW-1:0] ptr_next(logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (rd_en) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         count_ff <= count_ff + CW'(wr_en) - CW'(rd_en);
      end
   end

   assign rd_rec = mem_ff[rd_ptr_ff];
   assign empty  = (count_ff == '0);
   assign count  = count_ff;

endmodule

@@ rtl/ddsfe_back.sv @@
// ----------------------------------------------------------------------------
// ddsfe_back
// Holds one frame record and hands it out one byte per beat.
// ----------------------------------------------------------------------------
module ddsfe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 device_id,
   input  logic                       q_empty,
   input  ddsfe_pkg::frame_rec_type   q_rec,
   output logic                       q_pop,
   input  logic                       pop,
   output logic                       empty,
   output logic [7:0]                 frame_byte,
   output logic                       last_byte
);
   import ddsfe_pkg::*;

   logic          busy_ff, busy_in;
   logic [3:0]    idx_ff, idx_in;
   frame_rec_type rec_ff;
   logic          take, finish, load;

   assign take   = pop & busy_ff;
   assign finish = take & (idx_ff == POS_TAIL);
   assign load   = !q_empty & (!busy_ff | finish);

   always_comb begin
      busy_in = load | (busy_ff & !finish);
      idx_in  = idx_ff;
      if (load) begin
         idx_in = POS_HEAD;
      end else if (take) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= POS_HEAD;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= q_rec;
      end
   end

   always_comb begin
      unique case (idx_ff)
         POS_HEAD:   frame_byte = HEAD_BYTE;
         POS_ID:     frame_byte = device_id;
         POS_LEN:    frame_byte = LEN_BYTE;
         POS_CMD1:   frame_byte = CMD1_BYTE;
         POS_CMD2:   frame_byte = CMD2_BYTE;
         POS_RIGHT0: frame_byte = rec_ff.right_bits[7:0];
         POS_RIGHT1: frame_byte = rec_ff.right_bits[15:8];
         POS_RIGHT2: frame_byte = rec_ff.right_bits[23:16];
         POS_RIGHT3: frame_byte = rec_ff.right_bits[31:24];
         POS_LEFT0:  frame_byte = rec_ff.left_bits[7:0];
         POS_LEFT1:  frame_byte = rec_ff.left_bits[15:8];
         POS_LEFT2:  frame_byte = rec_ff.left_bits[23:16];
         POS_LEFT3:  frame_byte = rec_ff.left_bits[31:24];
         POS_CSUM:   frame_byte = rec_ff.checksum;
         POS_TAIL:   frame_byte = TAIL_BYTE;
         default:    frame_byte = 8'h00;
      endcase
   end

   assign last_byte = (idx_ff == POS_TAIL);
   assign empty     = !busy_ff;
   assign q_pop     = load;

endmodule

@@ rtl/diff_drive_speed_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// diff_drive_speed_frame_encoder
// Turns a linear and angular velocity command into a 15-byte wheel speed frame.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Beat contents
//   req       in         push / full            linear and angular velocity
//   rsp       out        empty / pop            one frame byte, last-byte flag
//   csr       in/out     psel penable pwrite    32-bit register write or read
//
// A command passes ten register stages (clamp, turn multiply, wheel sums,
// magnitudes, scale multiply in two, normalize in two, rounding, checksum),
// then through the queue into the record register of the byte stage. Its frame
// goes out one byte per beat, and new commands are taken while a slot is free.
// Synchronous reset empties pipeline and queue and restores register defaults.
// Stalled pops back up the queue; full rises once all slots are claimed.
//
`include "diff_drive_speed_frame_encoder_macros.svh"

module diff_drive_speed_frame_encoder #(
   parameter int FRAC_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   // Command channel.
   input  logic               push,
   output logic               full,
   input  logic signed [31:0] req_linear_velocity,
   input  logic signed [31:0] req_angular_velocity,
   // Frame byte channel.
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte,
   // Register port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import ddsfe_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cfg_type                 cfg_ff;
   logic [2:0]              reg_idx;
   logic                    wr_beat;
   logic                    accept;
   logic [CW-1:0]           credit_ff, credit_in;
   logic                    front_valid;
   frame_rec_type           front_rec;
   logic [FRONT_STAGES-1:0] front_busy;
   frame_rec_type           q_rec;
   logic                    q_empty, q_pop;
   logic [CW-1:0]           q_count;

   // ------------------------------------------------------------------------
   // Register port. The word index comes from the address above the byte
   // offset; writes to indexes past the last register are dropped.
   // ------------------------------------------------------------------------
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_beat = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_limit  <= 31'd13107;
         cfg_ff.angular_limit <= 31'd13107;
         cfg_ff.track_width   <= 31'd32768;
         cfg_ff.speed_scale   <= 16'd1000;
         cfg_ff.device_id     <= 8'd1;
      end else if (wr_beat) begin
         unique case (reg_idx)
            REG_LINEAR_LIMIT:  cfg_ff.linear_limit  <= pwdata[30:0];
            REG_ANGULAR_LIMIT: cfg_ff.angular_limit <= pwdata[30:0];
            REG_TRACK_WIDTH:   cfg_ff.track_width   <= pwdata[30:0];
            REG_SPEED_SCALE:   cfg_ff.speed_scale   <= pwdata[15:0];
            REG_DEVICE_ID:     cfg_ff.device_id     <= pwdata[7:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LINEAR_LIMIT:  prdata = {1'b0, cfg_ff.linear_limit};
         REG_ANGULAR_LIMIT: prdata = {1'b0, cfg_ff.angular_limit};
         REG_TRACK_WIDTH:   prdata = {1'b0, cfg_ff.track_width};
         REG_SPEED_SCALE:   prdata = {16'd0, cfg_ff.speed_scale};
         REG_DEVICE_ID:     prdata = {24'd0, cfg_ff.device_id};
         default:           prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Flow control. Each accepted command claims a queue slot at once; the
   // slot is returned when the back takes the record out of the queue. The
   // front pipeline itself never stalls, so a claimed slot is always free
   // when the record arrives.
   // ------------------------------------------------------------------------
   assign accept    = push & !full;
   assign full      = (credit_ff == '0);
   assign credit_in = credit_ff - CW'(accept) + CW'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= CW'(QUEUE_DEPTH);
      end else begin
         credit_ff <= credit_in;
      end
   end

   ddsfe_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .linear_velocity  (req_linear_velocity),
      .angular_velocity (req_angular_velocity),
      .cfg              (cfg_ff),
      .out_valid        (front_valid),
      .out_rec          (front_rec),
      .stage_valid      (front_busy)
   );

   ddsfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (front_valid),
      .wr_rec (front_rec),
      .rd_en  (q_pop),
      .rd_rec (q_rec),
      .empty  (q_empty),
      .count  (q_count)
   );

   ddsfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .device_id  (cfg_ff.device_id),
      .q_empty    (q_empty),
      .q_rec      (q_rec),
      .q_pop      (q_pop),
      .pop        (pop),
      .empty      (empty),
      .frame_byte (rsp_frame_byte),
      .last_byte  (rsp_last_byte)
   );

   // ------------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------------

   // Every queue slot is either free, holding a record, or claimed by a
   // command still in the front pipeline.
   `DDSFE_ASSERT_SAME(a_slot_balance, clock, reset, 1'b1, int'(credit_ff) + int'(q_count) + $countones(front_busy) == QUEUE_DEPTH, "queue slot accounting is off")

   // A record arriving from the front always finds room in the queue.
   `DDSFE_ASSERT_SAME(a_no_overflow, clock, reset, front_valid, int'(q_count) < QUEUE_DEPTH || q_pop, "frame record arrived at a full queue")

   // A waiting frame follows the previous one without a gap.
   `DDSFE_ASSERT_NEXT(a_back_to_back, clock, reset, pop && !empty && rsp_last_byte && !q_empty, !empty, "gap between queued frames")

   // Every frame starts with the head byte.
   `DDSFE_ASSERT_NEXT(a_frame_head, clock, reset, q_pop, rsp_frame_byte == HEAD_BYTE && !empty, "frame does not start with the head byte")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the differential-drive speed frame encoder: random
// and corner velocity commands under several register settings, every frame
// byte compared against a bit-exact software prediction of the wheel floats.
// ----------------------------------------------------------------------------
module tb_top;
   import ddsfe_pkg::*;

   localparam int FRAC_BITS = 16;
   // The slowest legal run is far below this. Assume every byte waits through
   // the sparsest pop pattern, every command waits out the longest sender gap,
   // and add the long hold. Even that sum stays well under the limit, so this
   // limit only trips on a hang.
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int LONG_HOLD        = 300;
   localparam int DRAIN_CYCLES     = 40;
   localparam int PHASES           = 8;
   localparam int RANDOM_PER_PHASE = 54;
   localparam int DIRECTED_COUNT   = 16;

   // One expected beat of the byte channel, tagged with its frame position so
   // that a mismatch report says where in the frame it went wrong.
   typedef struct {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic [3:0] pos;
   } frame_beat_type;

   // Holds a private copy of the register file, predicts the fifteen bytes of
   // each accepted command and checks the byte beats against them in order.
   class frame_scoreboard;
      cfg_type        cfg;
      frame_beat_type awaited_beats[$];
      int             errors;

      function new();
         errors             = 0;
         cfg.linear_limit   = 31'd13107;
         cfg.angular_limit  = 31'd13107;
         cfg.track_width    = 31'd32768;
         cfg.speed_scale    = 16'd1000;
         cfg.device_id      = 8'd1;
      endfunction

      task report(input string msg);
         $display("mismatch at %0t ns: %s", $time, msg);
         errors++;
      endtask

      function int pending();
         return awaited_beats.size();
      endfunction

      // Bits above the register width are dropped; unknown indexes are ignored.
      function void set_register(input logic [2:0] idx, input logic [31:0] value);
         case (idx)
            REG_LINEAR_LIMIT:  cfg.linear_limit  = value[30:0];
            REG_ANGULAR_LIMIT: cfg.angular_limit = value[30:0];
            REG_TRACK_WIDTH:   cfg.track_width   = value[30:0];
            REG_SPEED_SCALE:   cfg.speed_scale   = value[15:0];
            REG_DEVICE_ID:     cfg.device_id     = value[7:0];
            default: ;
         endcase
      endfunction

      task check_register(input logic [2:0] idx, input logic [31:0] got);
         logic [31:0] want;
         case (idx)
            REG_LINEAR_LIMIT:  want = 32'(cfg.linear_limit);
            REG_ANGULAR_LIMIT: want = 32'(cfg.angular_limit);
            REG_TRACK_WIDTH:   want = 32'(cfg.track_width);
            REG_SPEED_SCALE:   want = 32'(cfg.speed_scale);
            default:           want = 32'(cfg.device_id);
         endcase
         if (got !== want)
            report($sformatf("register %0d reads %08h, expected %08h", idx, got, want));
      endtask

      function logic signed [63:0] clamp_velocity(input logic signed [31:0] v,
                                                  input logic [30:0] lim);
         logic signed [63:0] wide;
         logic signed [63:0] bound;
         wide  = v;
         bound = $signed({33'd0, lim});
         if (wide > bound) return bound;
         if (wide < -bound) return -bound;
         return wide;
      endfunction

      // The wheel sum is in units of 2^-(2*FRAC_BITS+1). It is scaled exactly
      // to 80 bits and rounded once to single precision, ties to even.
      function logic [31:0] wheel_to_single(input logic signed [63:0] wheel);
         logic [63:0] mag;
         logic [79:0] scaled;
         logic [79:0] below;
         logic [24:0] mant;
         logic [31:0] bits;
         int          msb;
         int          shift;
         mag    = wheel[63] ? -wheel : wheel;
         scaled = 80'(mag) * 80'(cfg.speed_scale);
         // A zero product, whatever its sign or the scale, goes out as +0.0.
         if (scaled == '0) return 32'd0;
         msb = 0;
         for (int k = 0; k < 80; k++)
            if (scaled[k]) msb = k;
         if (msb <= 23) begin
            mant = 25'(scaled << (23 - msb));
         end else begin
            shift = msb - 23;
            mant  = 25'(scaled >> shift);
            below = scaled & ((80'd1 << (shift - 1)) - 80'd1);
            if (scaled[shift - 1] && (below != '0 || mant[0])) mant = mant + 25'd1;
         end
         // The hidden bit in the mantissa adds one to the exponent field, and a
         // rounding carry out of the mantissa adds another.
         bits = (32'(msb - 2 * FRAC_BITS - 1 + 126) << 23) + 32'(mant);
         if (wheel[63]) bits[31] = 1'b1;
         return bits;
      endfunction

      function void note_command(input logic signed [31:0] lin_cmd,
                                 input logic signed [31:0] ang_cmd);
         logic signed [63:0] lin;
         logic signed [63:0] ang;
         logic signed [63:0] base;
         logic signed [63:0] turn;
         logic [31:0]        right_bits;
         logic [31:0]        left_bits;
         logic [7:0]         frame [15];
         logic [7:0]         sum;
         frame_beat_type     beat;
         lin        = clamp_velocity(lin_cmd, cfg.linear_limit);
         ang        = clamp_velocity(ang_cmd, cfg.angular_limit);
         base       = lin <<< (FRAC_BITS + 1);
         turn       = ang * $signed({33'd0, cfg.track_width});
         right_bits = wheel_to_single(base + turn);
         left_bits  = wheel_to_single(base - turn);
         frame[POS_HEAD] = HEAD_BYTE;
         frame[POS_ID]   = cfg.device_id;
         frame[POS_LEN]  = LEN_BYTE;
         frame[POS_CMD1] = CMD1_BYTE;
         frame[POS_CMD2] = CMD2_BYTE;
         for (int k = 0; k < 4; k++) begin
            frame[POS_RIGHT0 + k] = right_bits[8 * k +: 8];
            frame[POS_LEFT0 + k]  = left_bits[8 * k +: 8];
         end
         sum = 8'd0;
         for (int k = 0; k < POS_CSUM; k++) sum = sum + frame[k];
         frame[POS_CSUM] = -sum;
         frame[POS_TAIL] = TAIL_BYTE;
         for (int k = 0; k <= POS_TAIL; k++) begin
            beat.frame_byte = frame[k];
            beat.last_byte  = (k == POS_TAIL);
            beat.pos        = 4'(k);
            awaited_beats.push_back(beat);
         end
      endfunction

      task check_beat(input logic [7:0] got_byte, input logic got_last);
         frame_beat_type want;
         if (awaited_beats.size() == 0) begin
            report($sformatf("byte %02h arrived with no frame pending", got_byte));
            return;
         end
         want = awaited_beats.pop_front();
         if (got_byte !== want.frame_byte)
            report($sformatf("frame byte %0d is %02h, expected %02h",
                             want.pos, got_byte, want.frame_byte));
         if (got_last !== want.last_byte)
            report($sformatf("last flag on frame byte %0d is %b, expected %b",
                             want.pos, got_last, want.last_byte));
      endtask
   endclass

   // Every input of the block starts at a known value.
   logic               clock                = 1'b0;
   logic               reset                = 1'b1;
   logic               push                 = 1'b0;
   logic               full;
   logic signed [31:0] req_linear_velocity  = '0;
   logic signed [31:0] req_angular_velocity = '0;
   logic               empty;
   logic               pop                  = 1'b0;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_last_byte;
   logic               psel                 = 1'b0;
   logic               penable              = 1'b0;
   logic               pwrite               = 1'b0;
   logic [4:0]         paddr                = '0;
   logic [31:0]        pwdata               = '0;
   logic [31:0]        prdata;
   logic               pready;

   frame_scoreboard frames;

   // Receiver pacing state and the one long hold that fills the block up.
   int   pop_percent  = 100;
   int   pattern_left = 0;
   int   hold_left    = 0;
   logic hold_request = 1'b0;
   logic hold_taken   = 1'b0;
   int   cycle_count  = 0;

   diff_drive_speed_frame_encoder #(
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_linear_velocity (req_linear_velocity),
      .req_angular_velocity(req_angular_velocity),
      .empty               (empty),
      .pop                 (pop),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_last_byte       (rsp_last_byte),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver pops with a probability that changes after each stretch of
   // random length. Full-rate stretches alternate with sparse ones, so stalls
   // land on every byte position of a frame. Once requested, it holds off once,
   // for a long hold set by LONG_HOLD, while the sender keeps offering commands,
   // which drives the block into back-pressure on its command side.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD;
         pop        <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_left <= $urandom_range(16, 80);
            case ($urandom_range(0, 5))
               0, 1:    pop_percent <= 100;
               2:       pop_percent <= 75;
               3:       pop_percent <= 50;
               4:       pop_percent <= 20;
               default: pop_percent <= 5;
            endcase
         end else begin
            pattern_left <= pattern_left - 1;
         end
         pop <= ($urandom_range(0, 99) < pop_percent);
      end
   end

   // A beat moves at a rising edge with pop high and empty low. Sampling here
   // sees the values from before the edge, as the block does.
   always @(posedge clock) begin
      if (!reset && pop && !empty) frames.check_beat(rsp_frame_byte, rsp_last_byte);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offers one command and returns at the edge where it was taken. push stays
   // high on return so that back-to-back commands follow without a gap.
   task automatic send_command(input logic signed [31:0] lin, input logic signed [31:0] ang);
      push                 <= 1'b1;
      req_linear_velocity  <= lin;
      req_angular_velocity <= ang;
      do @(posedge clock); while (full);
      frames.note_command(lin, ang);
   endtask

   // Lowers push and waits until every predicted byte has come out. Every
   // command yields a full frame, so once nothing is owed the block is idle.
   task automatic wait_for_frames();
      push <= 1'b0;
      while (frames.pending() != 0) @(posedge clock);
   endtask

   // One register access: a setup phase, then the access phase until pready.
   task automatic csr_access(input logic is_write, input logic [2:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      if (is_write) frames.set_register(idx, wdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Four of ten draws fall inside the current limit so the wheel arithmetic
   // is exercised unclamped. The rest sit at the limit edge, take full-range
   // random values, hit 32-bit corners, or are small values up to 0x40000.
   function automatic logic signed [31:0] random_velocity(input logic [30:0] lim);
      logic [31:0] mag;
      logic [31:0] corner [5];
      corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
      case ($urandom_range(0, 9))
         0, 1:       return $urandom;
         2, 3, 4, 5: mag = (lim == 0) ? 32'd0 : $urandom_range(0, lim);
         6, 7:       mag = 32'(lim) + $urandom_range(0, 2) - 1;
         8:          return corner[$urandom_range(0, 4)];
         default:    mag = $urandom_range(0, 32'h0004_0000);
      endcase
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // Commands go out in bursts of random length with random gaps between,
   // some of the gaps zero so that bursts also run into each other.
   task automatic run_random(input int count);
      int burst;
      int gap;
      while (count > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && count > 0) begin
            send_command(random_velocity(frames.cfg.linear_limit),
                         random_velocity(frames.cfg.angular_limit));
            burst--;
            count--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Corner commands: zero and unit steps, values at and just past the reset
   // limits, pairs that make one wheel exactly zero under the reset track
   // width, and the extremes of the 32-bit range in both fields.
   task automatic run_directed();
      logic signed [31:0] lin_set [DIRECTED_COUNT];
      logic signed [31:0] ang_set [DIRECTED_COUNT];
      lin_set = '{0, 1, -1, 0, 0, 13107, -13107, 13108, 0, 0, 3000, -3000, 65536,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
      ang_set = '{0, 0, 0, 1, -1, 0, 0, -13108, 13107, -13108, 12000, 12000, 65536,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
      for (int k = 0; k < DIRECTED_COUNT; k++) send_command(lin_set[k], ang_set[k]);
   endtask

   // Called only with nothing in flight. Phase 1 puts every register at its
   // top value, phase 2 zeroes the limits and the track width, phase 3 writes
   // values wider than the registers (speed scale masks to zero) and pokes
   // the unused addresses. Later phases pick random settings.
   task automatic configure(input int phase);
      logic [31:0] values [5];
      logic [31:0] rd;
      case (phase)
         1: values = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF,
                       32'h0000_00FF};
         2: values = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h0};
         3: values = '{32'hFFFF_FFFF, 32'h8000_3333, 32'hFFFF_8000, 32'hABCD_0000,
                       32'h1234_56A5};
         default: begin
            values[REG_LINEAR_LIMIT]  = ($urandom_range(0, 3) == 0) ?
                                        $urandom : $urandom_range(1, 32'h0004_0000);
            values[REG_ANGULAR_LIMIT] = ($urandom_range(0, 3) == 0) ?
                                        $urandom : $urandom_range(1, 32'h0004_0000);
            values[REG_TRACK_WIDTH]   = ($urandom_range(0, 3) == 0) ?
                                        $urandom : $urandom_range(32'h4000, 32'h0002_0000);
            values[REG_SPEED_SCALE]   = $urandom_range(1, 65535);
            values[REG_DEVICE_ID]     = $urandom;
         end
      endcase
      for (int k = REG_LINEAR_LIMIT; k <= REG_DEVICE_ID; k++)
         csr_access(1'b1, 3'(k), values[k], rd);
      if (phase == 3)
         for (int k = REG_DEVICE_ID + 1; k < 8; k++) csr_access(1'b1, 3'(k), $urandom, rd);
      for (int k = REG_LINEAR_LIMIT; k <= REG_DEVICE_ID; k++) begin
         csr_access(1'b0, 3'(k), 32'd0, rd);
         frames.check_register(3'(k), rd);
      end
   endtask

   initial begin
      frames = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) configure(phase);
         if (phase <= 1) run_directed();
         if (phase == 4) hold_request <= 1'b1;
         run_random(RANDOM_PER_PHASE);
         wait_for_frames();
      end
      // Leave room for any stray beat to show up and be flagged.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
